// ===== rtl/wlsc_pkg.sv =====
package wlsc_pkg;

	localparam int SLOT_COUNT_DEF = 32;
	localparam int SIDX_W         = 5;
	localparam int WORD_W         = 16;

	localparam logic [WORD_W-1:0] SLOT_MAGIC = 16'hD34A;
	localparam logic [WORD_W-1:0] WORD_MASK  = 16'hFFFF;

	localparam logic [1:0] FUNC_LOAD  = 2'd0;
	localparam logic [1:0] FUNC_READ  = 2'd1;
	localparam logic [1:0] FUNC_BEGIN = 2'd2;

	typedef struct packed {
		logic [1:0]        func;
		logic [SIDX_W-1:0] slot_index;
		logic [WORD_W-1:0] raw_magic;
		logic [WORD_W-1:0] raw_sequence;
		logic [WORD_W-1:0] raw_sequence_inverse;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0] session_id;
		logic [SIDX_W-1:0] written_index;
		logic              found_prior;
		logic [WORD_W-1:0] read_magic;
		logic [WORD_W-1:0] read_sequence;
		logic [WORD_W-1:0] read_sequence_inverse;
	} rsp_t;

	typedef struct packed {
		logic [WORD_W-1:0] magic;
		logic [WORD_W-1:0] seq;
		logic [WORD_W-1:0] inv;
	} slot_t;

endpackage

// ===== rtl/wlsc_mem.sv =====
module wlsc_mem
	import wlsc_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          re,
	input  logic                          we,
	input  logic [$clog2(SLOT_COUNT)-1:0] addr,
	input  slot_t                         wdata,
	output slot_t                         rdata
);

	slot_t                 mem [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] valid_q;
	slot_t                 rdata_q;
	logic                  rvalid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	// entries never written read as zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[addr] <= 1'b1;
			end
			if (re) begin
				rvalid_q <= valid_q[addr];
			end
		end
	end

	assign rdata = rvalid_q ? rdata_q : '0;

endmodule

// ===== rtl/wlsc_ctrl.sv =====
module wlsc_ctrl
	import wlsc_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  req_t                          req,
	output logic                          res_valid,
	input  logic                          res_take,
	output rsp_t                          res,
	output logic                          mem_re,
	output logic                          mem_we,
	output logic [$clog2(SLOT_COUNT)-1:0] mem_addr,
	output slot_t                         mem_wdata,
	input  slot_t                         mem_rdata
);

	localparam int IdxW = $clog2(SLOT_COUNT);
	localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOT_COUNT - 1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_READ  = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_WRITE = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t            state_q;
	logic              in_range_q;
	logic [IdxW-1:0]   cnt_q;
	logic              found_q;
	logic [IdxW-1:0]   newest_idx_q;
	logic [WORD_W-1:0] newest_seq_q;
	logic [WORD_W-1:0] session_q;
	logic [IdxW-1:0]   last_idx_q;
	logic              found_out_q;
	slot_t             rd_q;

	logic              accept;
	logic              in_range;
	logic [IdxW-1:0]   req_addr;
	logic              slot_ok;
	logic [WORD_W-1:0] seq_diff;
	logic              newer;
	logic [WORD_W-1:0] next_seq;
	logic [IdxW-1:0]   next_idx;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && (state_q == ST_IDLE);
	assign in_range  = (32'(req.slot_index) < 32'(SLOT_COUNT));
	assign req_addr  = IdxW'(req.slot_index);

	assign slot_ok  = (mem_rdata.magic == SLOT_MAGIC) &&
	                  ((mem_rdata.seq ^ mem_rdata.inv) == WORD_MASK) &&
	                  (mem_rdata.seq != '0);
	// serial compare: newer when the wrapped distance is 1 to 7fff
	assign seq_diff = mem_rdata.seq - newest_seq_q;
	assign newer    = (seq_diff != '0) && !seq_diff[WORD_W-1];

	always_comb begin
		next_seq = found_q ? newest_seq_q + WORD_W'(1) : WORD_W'(1);
		if (next_seq == '0) begin
			next_seq = WORD_W'(1);
		end
		if (!found_q || newest_idx_q == LastIdx) begin
			next_idx = '0;
		end else begin
			next_idx = newest_idx_q + IdxW'(1);
		end
	end

	always_comb begin
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = req_addr;
		mem_wdata = '{magic: req.raw_magic, seq: req.raw_sequence,
		              inv: req.raw_sequence_inverse};
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req.func)
						FUNC_LOAD: mem_we = in_range;
						FUNC_READ: mem_re = in_range;
						FUNC_BEGIN: begin
							mem_re   = 1'b1;
							mem_addr = '0;
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				mem_re   = (cnt_q != LastIdx);
				mem_addr = cnt_q + IdxW'(1);
			end
			ST_WRITE: begin
				mem_we    = 1'b1;
				mem_addr  = next_idx;
				mem_wdata = '{magic: SLOT_MAGIC, seq: next_seq, inv: ~next_seq};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			in_range_q   <= 1'b0;
			cnt_q        <= '0;
			found_q      <= 1'b0;
			newest_idx_q <= '0;
			newest_seq_q <= '0;
			session_q    <= '0;
			last_idx_q   <= '0;
			found_out_q  <= 1'b0;
			rd_q         <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						in_range_q   <= in_range;
						rd_q         <= '0;
						found_out_q  <= 1'b0;
						cnt_q        <= '0;
						found_q      <= 1'b0;
						newest_idx_q <= '0;
						newest_seq_q <= '0;
						case (req.func)
							FUNC_READ:  state_q <= ST_READ;
							FUNC_BEGIN: state_q <= ST_SCAN;
							default:    state_q <= ST_DONE;
						endcase
					end
				end
				ST_READ: begin
					if (in_range_q) begin
						rd_q <= mem_rdata;
					end
					state_q <= ST_DONE;
				end
				ST_SCAN: begin
					// first valid slot wins ties
					if (slot_ok && (!found_q || newer)) begin
						found_q      <= 1'b1;
						newest_idx_q <= cnt_q;
						newest_seq_q <= mem_rdata.seq;
					end
					cnt_q <= cnt_q + IdxW'(1);
					if (cnt_q == LastIdx) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					session_q   <= next_seq;
					last_idx_q  <= next_idx;
					found_out_q <= found_q;
					state_q     <= ST_DONE;
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid = (state_q == ST_DONE);
	assign res = '{
		session_id:            session_q,
		written_index:         SIDX_W'(last_idx_q),
		found_prior:           found_out_q,
		read_magic:            rd_q.magic,
		read_sequence:         rd_q.seq,
		read_sequence_inverse: rd_q.inv
	};

endmodule

// ===== rtl/wear_leveled_session_counter.sv =====
// Session counter kept in a wear-leveled ring of SLOT_COUNT slots (magic, sequence,
// complement), all zero after reset. A begin-session request scans every slot through
// the single slot memory port, one slot a cycle, picks the newest valid sequence by
// wrapping serial compare and writes sequence + 1 into the following slot (slot 0
// with sequence 1 when none is valid). One request is worked on at a time; a begin
// session lasts as long as the scan of every slot. The response sits in an output
// register, so the next request is taken while a response still waits.
module wear_leveled_session_counter
	import wlsc_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int IdxW = $clog2(SLOT_COUNT);

	logic            res_valid;
	logic            res_take;
	rsp_t            res;
	logic            mem_re;
	logic            mem_we;
	logic [IdxW-1:0] mem_addr;
	slot_t           mem_wdata;
	slot_t           mem_rdata;
	logic            rsp_valid_q;
	rsp_t            rsp_q;

	wlsc_ctrl #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.mem_re    (mem_re),
		.mem_we    (mem_we),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata)
	);

	wlsc_mem #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.re     (mem_re),
		.we     (mem_we),
		.addr   (mem_addr),
		.wdata  (mem_wdata),
		.rdata  (mem_rdata)
	);

	// output register is free when empty or being drained this cycle
	assign res_take = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== test/tb_wear_leveled_session_counter.sv =====
`timescale 1ns / 100ps

module tb_wear_leveled_session_counter;
	import wlsc_pkg::*;

	localparam int SLOTS = SLOT_COUNT_DEF;
	localparam int RANDOM_REQUESTS = 1100;
	localparam int CYCLE_LIMIT = 500000;
	localparam logic [1:0] FUNC_NONE = 2'd3;

	typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_LIGHT} stall_mode_t;

	class session_scoreboard;
		slot_t ring[SLOTS];
		logic [WORD_W-1:0] session;
		logic [SIDX_W-1:0] last_index;
		rsp_t expected_q[$];
		int errors;

		function new();
			for (int k = 0; k < SLOTS; k++)
				ring[k] = '0;
			session = '0;
			last_index = '0;
			errors = 0;
		endfunction

		function bit slot_ok(slot_t t);
			return t.magic == SLOT_MAGIC && (t.seq ^ t.inv) == WORD_MASK && t.seq != '0;
		endfunction

		function void note_request(req_t r);
			rsp_t o;
			bit found;
			int newest_idx;
			logic [WORD_W-1:0] newest_seq;
			logic [WORD_W-1:0] seq_gap;
			logic [WORD_W-1:0] next_seq;
			int next_idx;
			o = '0;
			case (r.func)
				FUNC_LOAD: begin
					ring[r.slot_index].magic = r.raw_magic;
					ring[r.slot_index].seq = r.raw_sequence;
					ring[r.slot_index].inv = r.raw_sequence_inverse;
				end
				FUNC_READ: begin
					o.read_magic = ring[r.slot_index].magic;
					o.read_sequence = ring[r.slot_index].seq;
					o.read_sequence_inverse = ring[r.slot_index].inv;
				end
				FUNC_BEGIN: begin
					found = 1'b0;
					newest_idx = 0;
					newest_seq = '0;
					for (int k = 0; k < SLOTS; k++) begin
						if (slot_ok(ring[k])) begin
							// serial compare, newer when the wrapped distance is 1..7fff
							seq_gap = ring[k].seq - newest_seq;
							if (!found || (seq_gap != '0 && !seq_gap[WORD_W-1])) begin
								found = 1'b1;
								newest_idx = k;
								newest_seq = ring[k].seq;
							end
						end
					end
					next_seq = found ? newest_seq + 1'b1 : WORD_W'(1);
					if (next_seq == '0)
						next_seq = WORD_W'(1);
					next_idx = found ? (newest_idx + 1) % SLOTS : 0;
					ring[next_idx].magic = SLOT_MAGIC;
					ring[next_idx].seq = next_seq;
					ring[next_idx].inv = ~next_seq;
					session = next_seq;
					last_index = SIDX_W'(next_idx);
					o.found_prior = found;
				end
				default: ;
			endcase
			o.session_id = session;
			o.written_index = last_index;
			expected_q.push_back(o);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		task report(string what);
			if (errors < 100)
				$display("mismatch at %0t: %s", $realtime, what);
			errors++;
		endtask

		task check_response(rsp_t got);
			rsp_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("response %h with no request waiting", got));
			end else begin
				want = expected_q.pop_front();
				if (got.session_id !== want.session_id)
					report($sformatf("session_id got %h want %h", got.session_id,
						want.session_id));
				if (got.written_index !== want.written_index)
					report($sformatf("written_index got %0d want %0d", got.written_index,
						want.written_index));
				if (got.found_prior !== want.found_prior)
					report($sformatf("found_prior got %b want %b", got.found_prior,
						want.found_prior));
				if (got.read_magic !== want.read_magic)
					report($sformatf("read_magic got %h want %h", got.read_magic,
						want.read_magic));
				if (got.read_sequence !== want.read_sequence)
					report($sformatf("read_sequence got %h want %h", got.read_sequence,
						want.read_sequence));
				if (got.read_sequence_inverse !== want.read_sequence_inverse)
					report($sformatf("read_sequence_inverse got %h want %h",
						got.read_sequence_inverse, want.read_sequence_inverse));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	session_scoreboard sb;
	int cycle_count = 0;
	stall_mode_t stall_mode = STALL_NONE;
	int burst_left = 0;
	int gap_len = 0;

	wear_leveled_session_counter u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	// receiver stall pattern, switched when the low seven bits of the cycle counter are zero
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count[6:0] == 7'd0)
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
		case (stall_mode)
			STALL_NONE: rsp_stall <= 1'b0;
			STALL_COIN: rsp_stall <= 1'($urandom_range(0, 1));
			STALL_HEAVY: rsp_stall <= (cycle_count % 5) != 0;
			default: rsp_stall <= $urandom_range(0, 7) == 0;
		endcase
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				sb.note_request(req);
			if (rsp_valid && !rsp_stall)
				sb.check_response(rsp);
		end
	end

	function automatic req_t mk(logic [1:0] f, int idx, logic [WORD_W-1:0] m,
			logic [WORD_W-1:0] s, logic [WORD_W-1:0] i);
		req_t r;
		r.func = f;
		r.slot_index = SIDX_W'(idx);
		r.raw_magic = m;
		r.raw_sequence = s;
		r.raw_sequence_inverse = i;
		return r;
	endfunction

	function automatic req_t good_slot(int idx, logic [WORD_W-1:0] s);
		return mk(FUNC_LOAD, idx, SLOT_MAGIC, s, ~s);
	endfunction

	function automatic req_t random_request();
		req_t r;
		int pick;
		int bitpos;
		logic [WORD_W-1:0] s;
		pick = $urandom_range(0, 99);
		bitpos = $urandom_range(0, WORD_W - 1);
		r = mk(FUNC_LOAD, $urandom_range(0, SLOTS - 1), 16'($urandom), 16'($urandom),
			16'($urandom));
		// most sequences for well-formed loads land near the live session so the scan ordering gets exercised
		if ($urandom_range(0, 2) == 0)
			s = 16'($urandom);
		else
			s = sb.session + 16'($urandom_range(0, 6)) - 16'd3;
		if (pick < 30) begin
			r.func = FUNC_BEGIN;
		end else if (pick < 68) begin
			r.raw_magic = SLOT_MAGIC;
			r.raw_sequence = s;
			r.raw_sequence_inverse = ~s;
			if (pick >= 55) begin
				case ($urandom_range(0, 2))
					0: r.raw_magic ^= 16'd1 << bitpos;
					1: r.raw_sequence_inverse ^= 16'd1 << bitpos;
					default: begin
						r.raw_sequence = '0;
						r.raw_sequence_inverse = WORD_MASK;
					end
				endcase
			end
		end else if (pick < 78) begin
			r.func = FUNC_LOAD;
		end else if (pick < 96) begin
			r.func = FUNC_READ;
		end else begin
			r.func = FUNC_NONE;
		end
		return r;
	endfunction

	// sender: bursts of random length, random gaps between them
	task automatic send_request(input req_t r);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap_len != 0) begin
				req_valid <= 1'b0;
				repeat (gap_len) @(posedge clk);
			end
		end
		burst_left--;
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		int sent;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fresh ring reads back zero, unused func with every field at all ones
		send_request(mk(FUNC_READ, 0, '0, '0, '0));
		send_request(mk(FUNC_NONE, SLOTS - 1, '1, '1, '1));
		// begin with nothing valid, then a normal successor
		send_request(mk(FUNC_BEGIN, 0, '0, '0, '0));
		send_request(mk(FUNC_BEGIN, SLOTS - 1, '1, '1, '1));
		// newest at the last slot holding ffff: both the ring and the sequence wrap
		send_request(good_slot(SLOTS - 1, 16'hFFFF));
		send_request(mk(FUNC_LOAD, 0, '0, '0, '0));
		send_request(mk(FUNC_LOAD, 1, '0, '0, '0));
		send_request(mk(FUNC_BEGIN, 0, '0, '0, '0));
		send_request(mk(FUNC_READ, 0, '0, '0, '0));
		// each flaw alone makes a slot invalid
		send_request(mk(FUNC_LOAD, 0, SLOT_MAGIC ^ 16'd1, 16'd5, ~16'd5));
		send_request(mk(FUNC_LOAD, SLOTS - 1, SLOT_MAGIC, '0, WORD_MASK));
		send_request(mk(FUNC_LOAD, 7, SLOT_MAGIC, 16'd9, ~16'd9 ^ 16'd1));
		send_request(mk(FUNC_BEGIN, 0, '0, '0, '0));
		// tie goes to the lower slot; distance of exactly 8000 is not newer
		send_request(good_slot(4, 16'd1));
		send_request(good_slot(9, 16'h8001));
		send_request(mk(FUNC_BEGIN, 0, '0, '0, '0));
		send_request(mk(FUNC_LOAD, 20, '1, '1, '1));
		send_request(mk(FUNC_READ, 20, '0, '0, '0));
		send_request(mk(FUNC_READ, SLOTS - 1, '0, '0, '0));
		send_request(good_slot(SLOTS - 1, 16'hFFFE));
		send_request(mk(FUNC_BEGIN, 0, '0, '0, '0));
		send_request(mk(FUNC_BEGIN, 0, '0, '0, '0));
		send_request(mk(FUNC_READ, 1, '0, '0, '0));
		drain();

		sent = 0;
		while (sent < RANDOM_REQUESTS) begin
			// now and then wipe the whole ring so begin starts over from nothing
			if ($urandom_range(0, 149) == 0) begin
				for (int k = 0; k < SLOTS; k++)
					send_request(mk(FUNC_LOAD, k, '0, '0, '0));
				sent += SLOTS;
			end
			send_request(random_request());
			sent++;
			if (sent == RANDOM_REQUESTS / 2)
				drain();
		end

		drain();
		repeat (SLOTS + 8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/wlsc_pkg.sv
rtl/wlsc_mem.sv
rtl/wlsc_ctrl.sv
rtl/wear_leveled_session_counter.sv
test/tb_wear_leveled_session_counter.sv
